// ===== rtl/multi_waveform_oscillator_top_defines.svh =====
// Assertion macros for the oscillator.
`ifndef MULTI_WAVEFORM_OSCILLATOR_TOP_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MWO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mwo: property violated");
`define MWO_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mwo: forbidden condition");
`else
`define MWO_ASSERT(lbl, clk, rst_n, prop)
`define MWO_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/mwo_pkg.sv =====
package mwo_pkg;

    localparam int DEF_PHASE_BITS           = 32;
    localparam int DEF_SINE_TABLE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS          = 16;

    localparam int FUNC_W = 3;
    localparam int STEP_W = 32;

    // pi/2 in Q30
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SINE   = 3'd0,
        FUNC_COSINE = 3'd1,
        FUNC_TRI    = 3'd2,
        FUNC_SAW    = 3'd3,
        FUNC_RSAW   = 3'd4,
        FUNC_PULSE  = 3'd5,
        FUNC_SQUARE = 3'd6
    } t_func;

    // Per-request control carried next to the table read
    typedef struct packed {
        logic is_sine;
        logic negate;
    } t_wave_ctl;

    // Quarter-wave entry k: round(FS * sin(pi/2 * k / 2^addr_bits)),
    // Q30 Taylor series to order 13. Elaboration only.
    function automatic longint sine_entry(input int k, input int addr_bits,
                                          input int sample_bits);
        longint theta;
        longint t2;
        longint term;
        longint sum;
        longint fs;
        longint v;
        begin
            fs    = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
            theta = (HALF_PI_Q30 * longint'(k)) >>> addr_bits;
            t2    = (theta * theta) >>> 30;
            term  = theta;
            sum   = theta;
            term  = ((term * t2) >>> 30) / 64'sd6;
            sum   = sum - term;
            term  = ((term * t2) >>> 30) / 64'sd20;
            sum   = sum + term;
            term  = ((term * t2) >>> 30) / 64'sd42;
            sum   = sum - term;
            term  = ((term * t2) >>> 30) / 64'sd72;
            sum   = sum + term;
            term  = ((term * t2) >>> 30) / 64'sd110;
            sum   = sum - term;
            term  = ((term * t2) >>> 30) / 64'sd156;
            sum   = sum + term;
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * fs + (64'sd1 <<< 29)) >>> 30;
            if (v > fs) begin
                v = fs;
            end
            return v;
        end
    endfunction

endpackage

// ===== rtl/mwo_sine_rom.sv =====
// Quarter-wave sine ROM, 2^ADDR_BITS+1 entries, registered read.
module mwo_sine_rom #(
    parameter int ADDR_BITS = mwo_pkg::DEF_SINE_TABLE_ADDR_BITS,
    parameter int DATA_BITS = mwo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS:0]   i_addr,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    logic [DATA_BITS-1:0] w_rom [DEPTH];
    logic [DATA_BITS-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign w_rom[g] = DATA_BITS'(mwo_pkg::sine_entry(g, ADDR_BITS, DATA_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/mwo_wave_gen.sv =====
// Waveform decode from the updated phase: table address for sine/cosine,
// direct value for the other shapes.
module mwo_wave_gen #(
    parameter int PHASE_BITS           = mwo_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_ADDR_BITS = mwo_pkg::DEF_SINE_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS          = mwo_pkg::DEF_SAMPLE_BITS
) (
    input  logic [mwo_pkg::FUNC_W-1:0]     i_func,
    input  logic [PHASE_BITS-1:0]          i_phase,
    input  logic                           i_wrap,
    output logic [SINE_TABLE_ADDR_BITS:0]  o_addr,
    output mwo_pkg::t_wave_ctl             o_ctl,
    output logic [SAMPLE_BITS-1:0]         o_alt
);

    localparam int A   = SINE_TABLE_ADDR_BITS;
    localparam int S   = SAMPLE_BITS;
    // pad the phase so at least S+1 top bits exist
    localparam int EXT = (S + 1 > PHASE_BITS) ? (S + 1 - PHASE_BITS) : 0;
    localparam int PW  = PHASE_BITS + EXT;

    localparam logic [A+1:0]  QUARTER = {2'b01, {A{1'b0}}};
    localparam logic [A:0]    FULL    = {1'b1, {A{1'b0}}};
    localparam logic [PW-1:0] PH_QTR  = {2'b01, {(PW-2){1'b0}}};
    localparam logic [S-1:0]  HALF    = {1'b1, {(S-1){1'b0}}};
    localparam logic [S-1:0]  FS      = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0]  NEG_ONE = HALF;

    logic [PW-1:0]  w_ext;
    logic [A+1:0]   w_idx;
    logic [A+1:0]   w_sel;
    logic [A-1:0]   w_k;
    logic [S-1:0]   w_u;
    logic [PW-1:0]  w_d;
    logic [S:0]     w_ut;
    logic [S-1:0]   w_low;
    logic [S-1:0]   w_saw;
    logic [S-1:0]   w_rsaw;
    logic [S-1:0]   w_tri;

    assign w_ext = PW'(i_phase) << EXT;

    // sine index; cosine is a quarter turn ahead
    assign w_idx = w_ext[PW-1 -: A+2];
    assign w_sel = (i_func == mwo_pkg::FUNC_COSINE) ? (w_idx + QUARTER) : w_idx;
    assign w_k   = w_sel[A-1:0];
    assign o_addr = w_sel[A] ? (FULL - {1'b0, w_k}) : {1'b0, w_k};

    // ramps: flipping the MSB subtracts one half
    assign w_u    = w_ext[PW-1 -: S];
    assign w_saw  = {~w_u[S-1], w_u[S-2:0]};
    assign w_rsaw = (w_u == '0) ? FS : (HALF - w_u);

    // triangle: rising half, then falling half with +1 saturated
    assign w_d   = w_ext - PH_QTR;
    assign w_ut  = w_d[PW-1 -: S+1];
    assign w_low = w_ut[S-1:0];
    assign w_tri = !w_ut[S] ? {~w_low[S-1], w_low[S-2:0]}
                 : ((w_low == '0) ? FS : (HALF - w_low));

    always_comb begin
        o_ctl.is_sine = 1'b0;
        o_ctl.negate  = w_sel[A+1];
        o_alt         = '0;
        unique case (i_func)
            mwo_pkg::FUNC_SINE,
            mwo_pkg::FUNC_COSINE: o_ctl.is_sine = 1'b1;
            mwo_pkg::FUNC_TRI:    o_alt = w_tri;
            mwo_pkg::FUNC_SAW:    o_alt = w_saw;
            mwo_pkg::FUNC_RSAW:   o_alt = w_rsaw;
            mwo_pkg::FUNC_PULSE:  o_alt = i_wrap ? FS : '0;
            mwo_pkg::FUNC_SQUARE: o_alt = w_ext[PW-1] ? NEG_ONE : FS;
            default:              o_alt = '0;
        endcase
    end

endmodule

// ===== rtl/multi_waveform_oscillator_top.sv =====
// Pipeline: an accepted request passes the input register, then phase add +
//   sine ROM read, then the output register.
// Throughput: 1 request per cycle; the stages stall only when the output is
//   held by the downstream side.
// Reset (i_rst_n low, synchronous): phase accumulator to zero, all stages empty.
`include "multi_waveform_oscillator_top_defines.svh"

module multi_waveform_oscillator_top #(
    parameter int PHASE_BITS           = mwo_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_ADDR_BITS = mwo_pkg::DEF_SINE_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS          = mwo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mwo_pkg::STEP_W-1:0]         s_axis_tdata,  // [31:0] phase_step
    input  logic [mwo_pkg::FUNC_W-1:0]         s_axis_tuser,  // [2:0] func
    // result side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sample [SAMPLE_BITS-1:0], wrapped [SAMPLE_BITS], zero pad above
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]   m_axis_tdata
);

    localparam int S     = SAMPLE_BITS;
    localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

    // ---------------------------------------------------------------
    // Stage flow control: each stage loads when it is empty or when
    // the stage after it is moving on.
    // ---------------------------------------------------------------
    logic r_s1_v;
    logic r_s2_v;
    logic r_out_v;
    logic w_out_free;
    logic w_s2_free;
    logic w_s1_adv;

    assign w_out_free    = !r_out_v || m_axis_tready;
    assign w_s2_free     = !r_s2_v || w_out_free;
    assign w_s1_adv      = r_s1_v && w_s2_free;
    assign s_axis_tready = !r_s1_v || w_s2_free;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic [mwo_pkg::FUNC_W-1:0] r_func;
    logic [PHASE_BITS-1:0]      r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tuser;
            r_step <= PHASE_BITS'(s_axis_tdata);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: phase accumulate, waveform decode, table read
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS:0]            w_sum;
    logic [PHASE_BITS-1:0]          w_phase_nx;
    logic                           w_wrap;
    logic [SINE_TABLE_ADDR_BITS:0]  w_addr;
    mwo_pkg::t_wave_ctl             w_ctl;
    logic [S-1:0]                   w_alt;
    logic [S-1:0]                   w_mag;

    mwo_pkg::t_wave_ctl             r_s2_ctl;
    logic [S-1:0]                   r_s2_alt;
    logic                           r_s2_wrap;

    assign w_sum      = {1'b0, r_phase} + {1'b0, r_step};
    assign w_phase_nx = w_sum[PHASE_BITS-1:0];
    assign w_wrap     = w_sum[PHASE_BITS];

    mwo_wave_gen #(
        .PHASE_BITS           (PHASE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS          (SAMPLE_BITS)
    ) u_wave_gen (
        .i_func  (r_func),
        .i_phase (w_phase_nx),
        .i_wrap  (w_wrap),
        .o_addr  (w_addr),
        .o_ctl   (w_ctl),
        .o_alt   (w_alt)
    );

    // table output register is part of stage 2
    mwo_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .DATA_BITS (SAMPLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_s1_adv),
        .i_addr (w_addr),
        .o_data (w_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_s2_v  <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_phase <= w_phase_nx;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_ctl  <= w_ctl;
            r_s2_alt  <= w_alt;
            r_s2_wrap <= w_wrap;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: quadrant sign for sine/cosine, output register
    // ---------------------------------------------------------------
    logic [S-1:0] n_sample;
    logic [S-1:0] r_sample;
    logic         r_wrap;

    assign n_sample = r_s2_ctl.is_sine ? (r_s2_ctl.negate ? (S'(0) - w_mag) : w_mag)
                                       : r_s2_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s2_v) begin
            r_sample <= n_sample;
            r_wrap   <= r_s2_wrap;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'({r_wrap, r_sample});

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // phase moves only when a request leaves the input register
    `MWO_ASSERT(a_phase_hold, i_clk, i_rst_n, !w_s1_adv |=> $stable(r_phase))
    // the stored wrap flag matches the accumulator going backwards
    `MWO_ASSERT(a_wrap_flag, i_clk, i_rst_n, w_s1_adv |=> (r_s2_wrap == (r_phase < $past(r_phase))))
    // back-pressure at the input only with every stage occupied
    `MWO_NEVER(a_ready_full, i_clk, i_rst_n, !s_axis_tready && !(r_s1_v && r_s2_v && r_out_v))

endmodule

// ===== sim/multi_waveform_oscillator_top_tb.sv =====
module multi_waveform_oscillator_top_tb;

    localparam int          RUN_LIMIT     = 200000;
    localparam int          RANDOM_COUNT  = 800;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          REPORT_MAX    = 10;
    localparam int          FULL_SCALE    = 32767;
    localparam int          NEG_ONE       = -32768;
    localparam int          QTR_ADDR_BITS = 10;
    localparam int          QTR_LEN       = (1 << QTR_ADDR_BITS) + 1;
    localparam longint      PI_HALF_Q30   = 64'sd1686629713;
    // selector code outside the enum: phase advances, sample is zero
    localparam logic [2:0]  FUNC_UNUSED   = 3'd7;

    typedef struct packed {
        logic [15:0] sample;
        logic        wrapped;
    } t_osc_result;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] step;
        bit          typed;    // expectation given in the row
        logic [15:0] sample;
        logic        wrapped;
    } t_osc_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] phase_step
    logic [2:0]  s_axis_tuser  = '0;    // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] sample, [16] wrapped, [23:17] zero

    int          quarter_sine [0:QTR_LEN-1];
    logic [31:0] osc_phase;
    t_osc_result sample_q [$];
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          steady;               // no idling on either side while set

    multi_waveform_oscillator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // quadrant folding of the quarter-wave table
    function automatic int sine_lookup(input logic [11:0] idx);
        int k;
        int mag;
        k   = int'(idx[9:0]);
        mag = idx[10] ? quarter_sine[(1 << QTR_ADDR_BITS) - k] : quarter_sine[k];
        return idx[11] ? -mag : mag;
    endfunction

    // advance the phase by one tick and form the sample from the new phase
    function automatic t_osc_result predict_sample(input logic [2:0] fn,
                                                   input logic [31:0] step);
        logic [32:0] sum;
        logic [31:0] tri_phase;
        int          top;
        int          u;
        int          v;
        t_osc_result r;
        sum       = {1'b0, osc_phase} + {1'b0, step};
        r.wrapped = sum[32];
        osc_phase = sum[31:0];
        top       = int'(osc_phase[31:16]);
        v         = 0;
        case (fn)
            mwo_pkg::FUNC_SINE:   v = sine_lookup(osc_phase[31:20]);
            mwo_pkg::FUNC_COSINE: v = sine_lookup(osc_phase[31:20] + 12'd1024);
            mwo_pkg::FUNC_TRI: begin
                // shift back a quarter turn: zero and falling at phase zero, lowest a quarter turn in
                tri_phase = osc_phase - 32'h4000_0000;
                u = int'(tri_phase[31:15]);
                if (u < 65536) begin
                    v = u - 32768;
                end else begin
                    v = (98304 - u > FULL_SCALE) ? FULL_SCALE : 98304 - u;
                end
            end
            mwo_pkg::FUNC_SAW:    v = top - 32768;
            mwo_pkg::FUNC_RSAW:   v = (32768 - top > FULL_SCALE) ? FULL_SCALE : 32768 - top;
            mwo_pkg::FUNC_PULSE:  v = r.wrapped ? FULL_SCALE : 0;
            mwo_pkg::FUNC_SQUARE: v = osc_phase[31] ? NEG_ONE : FULL_SCALE;
            default:              v = 0;
        endcase
        r.sample = v[15:0];
        return r;
    endfunction

    // one request; random gaps before it, held until accepted
    task automatic send_request(input logic [2:0] fn, input logic [31:0] step,
                                input bit typed, input t_osc_result given);
        t_osc_result r;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            s_axis_tuser  <= 3'($urandom_range(7));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= step;
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_sample(fn, step);
        sample_q.push_back(typed ? given : r);
    endtask

    // result side: random stalls, changed at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        t_osc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_q.size() == 0) begin
                if (err_count < REPORT_MAX) begin
                    $display("unexpected result: sample %h wrapped %b",
                             m_axis_tdata[15:0], m_axis_tdata[16]);
                end
                err_count++;
            end else begin
                want = sample_q.pop_front();
                if (m_axis_tdata[15:0] !== want.sample
                        || m_axis_tdata[16] !== want.wrapped) begin
                    if (err_count < REPORT_MAX) begin
                        $display("mismatch: sample exp %h got %h, wrapped exp %b got %b",
                                 want.sample, m_axis_tdata[15:0],
                                 want.wrapped, m_axis_tdata[16]);
                    end
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        longint      theta;
        longint      t2;
        longint      term;
        longint      acc;
        longint      v;
        logic [2:0]  fn;
        logic [31:0] step;
        t_osc_row    rows [$];
        t_osc_result none;

        steady      = 1'b0;
        osc_phase   = '0;
        none        = '0;

        // quarter-wave table, Q30 Taylor series to order 13
        for (int k = 0; k < QTR_LEN; k++) begin
            theta = (PI_HALF_Q30 * longint'(k)) >>> QTR_ADDR_BITS;
            t2    = (theta * theta) >>> 30;
            term  = theta;
            acc   = theta;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * t2) >>> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = (acc * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
            quarter_sine[k] = (v > FULL_SCALE) ? FULL_SCALE : int'(v);
        end

        // directed requests; phase noted after each row
        rows = '{
            '{mwo_pkg::FUNC_SINE,   32'h0000_0000, 1, 16'h0000, 1'b0},  // 0
            '{mwo_pkg::FUNC_COSINE, 32'h0000_0000, 1, 16'h7FFF, 1'b0},
            '{mwo_pkg::FUNC_TRI,    32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_SAW,    32'h0000_0000, 1, 16'h8000, 1'b0},
            '{mwo_pkg::FUNC_RSAW,   32'h0000_0000, 1, 16'h7FFF, 1'b0},  // plus one clipped
            '{mwo_pkg::FUNC_PULSE,  32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_SQUARE, 32'h0000_0000, 1, 16'h7FFF, 1'b0},
            '{FUNC_UNUSED,          32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_PULSE,  32'hFFFF_FFFF, 1, 16'h0000, 1'b0},  // FFFFFFFF, no carry
            '{mwo_pkg::FUNC_PULSE,  32'h0000_0001, 1, 16'h7FFF, 1'b1},  // 0, wraps
            '{mwo_pkg::FUNC_SQUARE, 32'h8000_0000, 1, 16'h8000, 1'b0},  // 80000000
            '{mwo_pkg::FUNC_SINE,   32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_SAW,    32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_RSAW,   32'h7FFF_FFFF, 1, 16'h8001, 1'b0},  // FFFFFFFF
            '{FUNC_UNUSED,          32'h0000_0001, 1, 16'h0000, 1'b1},  // 0, wrap on unused code
            '{mwo_pkg::FUNC_SINE,   32'h4000_0000, 1, 16'h7FFF, 1'b0},  // 40000000
            '{mwo_pkg::FUNC_COSINE, 32'h0000_0000, 1, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_TRI,    32'h0000_0000, 1, 16'h8000, 1'b0},  // bottom of the ramp
            '{mwo_pkg::FUNC_TRI,    32'h4000_0000, 1, 16'h0000, 1'b0},  // 80000000
            '{mwo_pkg::FUNC_TRI,    32'h4000_0000, 1, 16'h7FFF, 1'b0},  // C0000000, top clipped
            '{mwo_pkg::FUNC_SINE,   32'h1234_5678, 0, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_COSINE, 32'hAAAA_AAAA, 0, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_TRI,    32'h5555_5555, 0, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_SAW,    32'hFFFF_FFFF, 0, 16'h0000, 1'b0},
            '{mwo_pkg::FUNC_RSAW,   32'h8000_0001, 0, 16'h0000, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_request(rows[i].func, rows[i].step, rows[i].typed,
                         '{rows[i].sample, rows[i].wrapped});
        end

        for (int i = 0; i < RANDOM_COUNT; i++) begin
            steady = (i >= 200 && i < 350);
            if (i == 400) begin
                // hold off until every pending result is back
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (sample_q.size() != 0) @(posedge i_clk);
            end
            fn = 3'($urandom_range(7));
            case ($urandom_range(4))
                0:       step = $urandom();
                1:       step = $urandom_range(255);
                2:       step = 32'hFFFF_FFFF - $urandom_range(255);
                3:       step = {2'($urandom_range(3)), 30'h0} + 32'($urandom_range(1));
                default: step = $urandom() >> $urandom_range(31);
            endcase
            send_request(fn, step, 1'b0, none);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_count += sample_q.size();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== multi_waveform_oscillator_top.f =====
+incdir+rtl
rtl/mwo_pkg.sv
rtl/mwo_sine_rom.sv
rtl/mwo_wave_gen.sv
rtl/multi_waveform_oscillator_top.sv
sim/multi_waveform_oscillator_top_tb.sv
